[hw/rtl/float32_to_fp10_convert_assert.svh]
// Assertion macros for the checker file of the converter.
`ifndef FLOAT32_TO_FP10_CONVERT_ASSERT_SVH
`define FLOAT32_TO_FP10_CONVERT_ASSERT_SVH

// Checked only outside reset.
`define F2F10_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define F2F10_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

[hw/rtl/f2f10_pkg.sv]
// Widths and format constants for the float32 to 10-bit minifloat converter.
package f2f10_pkg;

  localparam int F32_W  = 32;
  localparam int FP10_W = 16;
  localparam int MAG_W  = F32_W - 1;
  localparam int CODE_W = 9;

  localparam logic [FP10_W-1:0] SIGN_FILL      = 16'hfe00;
  localparam logic [CODE_W-1:0] FP10_INF_CODE  = 9'h1f0;
  localparam logic [CODE_W-1:0] FP10_NAN_CODE  = 9'h1f1;
  localparam logic [MAG_W-1:0]  MAG_INF_LIMIT  = 31'h477c0000;
  localparam logic [MAG_W-1:0]  MAG_ZERO_LIMIT = 31'h36000000;
  localparam logic [MAG_W-1:0]  F32_INF_MAG    = 31'h7f800000;
  localparam logic [7:0]        NORM_MIN_EXP   = 8'd113;
  localparam logic [7:0]        NORM_EXP_OFS   = 8'd112;
  localparam logic [7:0]        DEN_SHIFT_BASE = 8'd132;

endpackage

[hw/rtl/f2f10_stage.sv]
// One valid/ready register stage that holds a word until downstream takes it.
module f2f10_stage
  import f2f10_pkg::*;
#(
  parameter int Width = F32_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [Width-1:0] up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output logic [Width-1:0] dn_data
);

  logic             full;
  logic [Width-1:0] held;

  // Take a new word when empty or when the held one leaves this cycle.
  assign up_ready = !full || dn_ready;
  assign dn_valid = full;
  assign dn_data  = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (up_ready) begin
      full <= up_valid;
    end
    if (up_valid && up_ready) begin
      held <= up_data;
    end
  end

endmodule

[hw/rtl/f2f10_core.sv]
// Combinational float32 to 10-bit minifloat conversion, round to nearest even.
module f2f10_core
  import f2f10_pkg::*;
(
  input  logic [F32_W-1:0]  float_bits,
  output logic [FP10_W-1:0] fp10_word
);

  logic              sign;
  logic [MAG_W-1:0]  mag;
  logic [7:0]        expo;
  logic [22:0]       frac;
  logic [23:0]       mant;
  logic [4:0]        sh;
  logic [4:0]        sh_m1;
  logic [23:0]       rsh;
  logic              den_sticky;
  logic              den_inc;
  logic [4:0]        den_q;
  logic              nrm_inc;
  logic [CODE_W-1:0] nrm_code;
  logic [CODE_W-1:0] code;

  assign sign = float_bits[F32_W-1];
  assign mag  = float_bits[MAG_W-1:0];
  assign expo = mag[30:23];
  assign frac = mag[22:0];
  assign mant = {1'b1, frac};

  // Denormal range: exponent 108..112 gives a right shift of 20..24.
  assign sh         = 5'(DEN_SHIFT_BASE - expo);
  assign sh_m1      = sh - 5'd1;
  assign rsh        = mant >> sh_m1;
  assign den_sticky = |(mant & ~({24{1'b1}} << sh_m1));
  assign den_inc    = rsh[0] && (rsh[1] || den_sticky);
  assign den_q      = {1'b0, rsh[4:1]} + {4'b0, den_inc};

  // Normal range: round bit 18, sticky below it; carry may bump the exponent.
  assign nrm_inc  = frac[18] && (frac[19] || (|frac[17:0]));
  assign nrm_code = {5'(expo - NORM_EXP_OFS), 4'b0} + {5'b0, frac[22:19]}
                  + {8'b0, nrm_inc};

  always_comb begin
    if (mag > F32_INF_MAG) begin
      code = FP10_NAN_CODE;
    end else if (mag >= MAG_INF_LIMIT) begin
      code = FP10_INF_CODE;
    end else if (mag <= MAG_ZERO_LIMIT) begin
      code = '0;
    end else if (expo < NORM_MIN_EXP) begin
      code = {4'b0, den_q};
    end else begin
      code = nrm_code;
    end
  end

  assign fp10_word = (sign ? SIGN_FILL : '0) | {7'b0, code};

endmodule

[hw/rtl/float32_to_fp10_convert.sv]
// Top level: input register, conversion logic, result register.
//
//   channel | handshake          | word
//   --------+--------------------+------------------
//   input   | in_valid/in_ready  | float_bits [31:0]
//   output  | out_valid/out_ready| fp10_word  [15:0]
//
// Accepted words pass the input register, then the result register. The conversion logic
// between the registers sets the clock limit. One word per cycle while out_ready is high.
// Synchronous reset empties both registers.
// A stalled result holds while the input register still takes one more word.
module float32_to_fp10_convert
  import f2f10_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [F32_W-1:0]  float_bits,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [FP10_W-1:0] fp10_word
);

  logic              mid_valid;
  logic              mid_ready;
  logic [F32_W-1:0]  mid_bits;
  logic [FP10_W-1:0] conv_word;

  f2f10_stage #(.Width(F32_W)) u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (float_bits),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .dn_data  (mid_bits)
  );

  f2f10_core u_core (
    .float_bits (mid_bits),
    .fp10_word  (conv_word)
  );

  f2f10_stage #(.Width(FP10_W)) u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .up_valid (mid_valid),
    .up_ready (mid_ready),
    .up_data  (conv_word),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (fp10_word)
  );

endmodule

[hw/rtl/f2f10_checker.sv]
// Port-level checks for the converter, bound to the top level.
`include "float32_to_fp10_convert_assert.svh"

module f2f10_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [31:0] float_bits,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] fp10_word
);

  // A stalled result word holds.
  `F2F10_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(fp10_word), "result word changed while stalled")

  // With the sink ready after the accept, an accepted word shows at the output.
  `F2F10_ASSERT(a_latency, in_valid && in_ready ##1 out_ready |=> out_valid, "accepted word did not reach the output")

  // A negative input gives a result with the sign set.
  `F2F10_ASSERT(a_sign, in_valid && in_ready && float_bits[31] ##1 out_ready |=> out_valid && fp10_word[15], "sign lost")

  // A ready sink never blocks the input.
  `F2F10_ASSERT_ANY(a_no_block, out_ready |-> in_ready, "input stalled with output ready")

endmodule

bind float32_to_fp10_convert f2f10_checker u_f2f10_checker (.*);
